### hw/rtl/assert_macros.svh
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define EIEC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("eiec assertion failed");

`define EIEC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eiec implication failed");

`else

`define EIEC_ASSERT(label, clk, rst, prop)

`define EIEC_ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/eiec_pkg.sv
// types and constants of the external interrupt edge controller
`timescale 1ns / 1ps

package eiec_pkg;

   localparam int NUM_LINES = 16;
   localparam int NUM_PORTS = 4;

   localparam int LINE_WORD  = 16;
   localparam int SEL_W      = 4;
   localparam int PIN_W      = 64;
   localparam int SEL_FLAT_W = LINE_WORD * SEL_W;

   localparam logic [LINE_WORD-1:0] LINE_BITS =
      LINE_WORD'((17'h1 << NUM_LINES) - 17'h1);

   // one nibble of ones for each implemented line
   function automatic logic [SEL_FLAT_W-1:0] sel_bits_f();
      logic [SEL_FLAT_W-1:0] m;
      m = '0;
      for (int i = 0; i < LINE_WORD; i++) begin
         if (i < NUM_LINES) m[i*SEL_W +: SEL_W] = {SEL_W{1'b1}};
      end
      return m;
   endfunction

   localparam logic [SEL_FLAT_W-1:0] SEL_BITS = sel_bits_f();

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_WRITE  = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   typedef logic [2:0] addr_type;
   localparam addr_type ADDR_MASK    = 3'd0;
   localparam addr_type ADDR_RISING  = 3'd1;
   localparam addr_type ADDR_FALLING = 3'd2;
   localparam addr_type ADDR_PENDING = 3'd3;

   typedef struct packed {
      logic [PIN_W-1:0]     pin_levels;
      logic [LINE_WORD-1:0] write_data;
      addr_type             reg_addr;
   } req_fields_type;

   typedef struct packed {
      logic [3:0]           irq_line;
      logic                 irq_valid;
      logic [LINE_WORD-1:0] irq_pending;
      logic [LINE_WORD-1:0] read_data;
   } rsp_fields_type;

endpackage

### hw/rtl/external_interrupt_edge_controller_top.sv
// top level of the external interrupt edge controller
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sixteen-line external interrupt controller. Each request is a pin sample, a register
// write or a register read (tuser selects which) and yields exactly one response with the
// read data and the interrupt status after that request. A request is taken every clock
// while the response side keeps up: it is held in the input register and is applied to the
// register set as it moves into the response register. The response register is the only
// buffer toward the response side, so backpressure there stalls the input register at once.
module external_interrupt_edge_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // reg_addr [2:0], write_data [18:3], pin_levels [82:19], zero fill [87:83]
   input  logic [87:0] req_tdata,
   // func [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data [15:0], irq_pending [31:16], irq_valid [32], irq_line [36:33], zero [39:37]
   output logic [39:0] rsp_tdata
);
   import eiec_pkg::*;

   localparam int REQ_W = $bits(req_fields_type);
   localparam int RSP_W = $bits(rsp_fields_type);

   logic                  in_valid_ff;
   logic [1:0]            in_func_ff;
   req_fields_type        in_req_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_fields_type        out_rsp_ff, out_rsp_in;

   logic [LINE_WORD-1:0]  prev_ff, prev_in;
   logic [LINE_WORD-1:0]  mask_ff, mask_in;
   logic [LINE_WORD-1:0]  rise_ff, rise_in;
   logic [LINE_WORD-1:0]  fall_ff, fall_in;
   logic [LINE_WORD-1:0]  pend_ff, pend_in;
   logic [SEL_FLAT_W-1:0] sel_ff, sel_in;

   logic                  advance;
   logic [LINE_WORD-1:0]  now_levels;
   logic [LINE_WORD-1:0]  act;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(40 - RSP_W)'(0), out_rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_func_ff <= req_tuser;
         in_req_ff  <= req_fields_type'(req_tdata[REQ_W-1:0]);
      end
   end

   // line levels seen through each line's port select
   always_comb begin
      logic [SEL_W-1:0] p;
      now_levels = '0;
      for (int i = 0; i < LINE_WORD; i++) begin
         p = sel_ff[i*SEL_W +: SEL_W];
         if (i < NUM_LINES && p < SEL_W'(NUM_PORTS)) begin
            now_levels[i] = in_req_ff.pin_levels[{p[1:0], 4'(i)}];
         end
      end
   end

   always_comb begin
      logic [LINE_WORD-1:0] rdata;
      logic [LINE_WORD-1:0] wdata;
      addr_type             addr;
      logic [1:0]           word;
      logic [3:0]           line;
      prev_in = prev_ff;
      mask_in = mask_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      pend_in = pend_ff;
      sel_in  = sel_ff;
      rdata   = '0;
      wdata   = in_req_ff.write_data;
      addr    = in_req_ff.reg_addr;
      word    = addr[1:0];
      line    = '0;
      unique case (in_func_ff)
         FUNC_SAMPLE: begin
            pend_in = (pend_ff | (now_levels & ~prev_ff & rise_ff)
                               | (~now_levels & prev_ff & fall_ff)) & LINE_BITS;
            prev_in = now_levels & LINE_BITS;
         end
         FUNC_WRITE: begin
            priority if (addr == ADDR_MASK)    mask_in = wdata & LINE_BITS;
            else if (addr == ADDR_RISING)      rise_in = wdata & LINE_BITS;
            else if (addr == ADDR_FALLING)     fall_in = wdata & LINE_BITS;
            else if (addr == ADDR_PENDING)     pend_in = pend_ff & ~wdata & LINE_BITS;
            else begin
               sel_in[word*LINE_WORD +: LINE_WORD] = wdata;
               sel_in = sel_in & SEL_BITS;
            end
         end
         FUNC_READ: begin
            priority if (addr == ADDR_MASK)    rdata = mask_ff;
            else if (addr == ADDR_RISING)      rdata = rise_ff;
            else if (addr == ADDR_FALLING)     rdata = fall_ff;
            else if (addr == ADDR_PENDING)     rdata = pend_ff;
            else                               rdata = sel_ff[word*LINE_WORD +: LINE_WORD];
         end
         default: begin
         end
      endcase
      act = pend_in & mask_in;
      // lowest set line wins
      for (int i = LINE_WORD - 1; i >= 0; i--) begin
         if (act[i]) line = 4'(i);
      end
      out_rsp_in.read_data   = rdata;
      out_rsp_in.irq_pending = act;
      out_rsp_in.irq_valid   = |act;
      out_rsp_in.irq_line    = line;
   end

   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
         mask_ff      <= '0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         pend_ff      <= '0;
         sel_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            prev_ff <= prev_in;
            mask_ff <= mask_in;
            rise_ff <= rise_in;
            fall_ff <= fall_in;
            pend_ff <= pend_in;
            sel_ff  <= sel_in;
         end
      end
      if (advance) out_rsp_ff <= out_rsp_in;
   end

   `EIEC_ASSERT(a_valid_flag, clock, reset, !out_valid_ff || (out_rsp_ff.irq_valid == (out_rsp_ff.irq_pending != '0)))
   `EIEC_ASSERT_IMPL(a_line_set, clock, reset, out_valid_ff && out_rsp_ff.irq_valid, out_rsp_ff.irq_pending[out_rsp_ff.irq_line])
   `EIEC_ASSERT_IMPL(a_line_lowest, clock, reset, out_valid_ff, (out_rsp_ff.irq_pending & ((16'h1 << out_rsp_ff.irq_line) - 16'h1)) == '0)
   `EIEC_ASSERT(a_pend_lines, clock, reset, (pend_ff & ~LINE_BITS) == '0)
   `EIEC_ASSERT_IMPL(a_pend_set_by_sample, clock, reset, (pend_ff & ~$past(pend_ff)) != '0, $past(advance) && ($past(in_func_ff) == FUNC_SAMPLE))

endmodule
